// ----- sv/ssnp_pkg.sv -----
// ============================================================================
// ssnp_pkg: shared types and constants of the size suffix number parser
// Field widths, the scan phase and radix codes, and the record that carries
// a finished scan from the character scanner to the scaling pipeline.
// ============================================================================
package ssnp_pkg;

    // Field widths fixed by the interface
    localparam int CH_W     = 8;
    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 6;
    localparam int CFG_W    = 13;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // Default number of counted characters after the prefix
    localparam int MAX_CHARS_DEF = 47;

    // Reset value of both size registers
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd64;

    // Register indexes on the configuration port
    typedef enum logic { REG_BLOCK_BYTES = 1'b0, REG_KEY_BYTES = 1'b1 } reg_idx_t;

    // Unit factor split into a small multiplier and a left shift
    localparam int MULT_W  = CFG_W;
    localparam int SHIFT_W = 6;

    // Digit code for a character that is no digit in any base
    localparam logic [5:0] DIGIT_NONE = 6'd63;

    // Scan phases, one-hot
    typedef enum logic [6:0] {
        PH_START  = 7'b0000001,
        PH_PFX    = 7'b0000010,
        PH_LEAD   = 7'b0000100,
        PH_SIGNED = 7'b0001000,
        PH_ZERO   = 7'b0010000,
        PH_ZEROX  = 7'b0100000,
        PH_DIGITS = 7'b1000000
    } phase_t;

    // Radix modes
    typedef enum logic [1:0] {
        RM_DEC     = 2'd0,
        RM_HEX     = 2'd1,
        RM_AUTO    = 2'd2,
        RM_AUTOHEX = 2'd3
    } radix_t;

    // Finished scan of one string, handed to the scaling pipeline
    typedef struct packed {
        logic [VALUE_W-1:0]  accum;
        logic                negative;
        logic                saturated;
        logic                converted;
        logic                has_suffix;
        logic [CH_W-1:0]     suffix_ch;
        logic [OFFSET_W-1:0] stop_offset;
        logic                fully_parsed;
    } scan_res_t;

    // Value of a character as a digit in bases up to 36
    function automatic logic [5:0] digit_of(input logic [CH_W-1:0] c);
        logic [5:0] d;
        d = DIGIT_NONE;
        if (c inside {["0":"9"]})
        begin
            d = 6'(c - "0");
        end
        else if (c inside {["a":"z"]})
        begin
            d = 6'(c - "a" + 8'd10);
        end
        else if (c inside {["A":"Z"]})
        begin
            d = 6'(c - "A" + 8'd10);
        end
        return d;
    endfunction

    // Numeric base of a radix mode
    function automatic logic [5:0] base_of(input radix_t r);
        logic [5:0] b;
        case (r)
            RM_DEC:  b = 6'd10;
            RM_AUTO: b = 6'd8;
            default: b = 6'd16;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/ssnp_cfg.sv -----
// ============================================================================
// ssnp_cfg: configuration registers
// Holds the block size and key size used by the e, y and x unit suffixes,
// written and read through a simple APB-style port.
// ============================================================================
module ssnp_cfg
    import ssnp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [CFG_W-1:0]  block_bytes,
    output logic [CFG_W-1:0]  key_bytes
);

    logic [CFG_W-1:0] block_reg;
    logic [CFG_W-1:0] key_reg;
    logic             wr_en;
    reg_idx_t         idx;

    // Registers are word aligned, so one address bit picks the register.
    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_reg <= CFG_RESET;
            key_reg   <= CFG_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_BLOCK_BYTES: block_reg <= pwdata[CFG_W-1:0];
                REG_KEY_BYTES:   key_reg   <= pwdata[CFG_W-1:0];
                default:         block_reg <= block_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_BLOCK_BYTES: prdata = DATA_W'(block_reg);
            REG_KEY_BYTES:   prdata = DATA_W'(key_reg);
            default:         prdata = '0;
        endcase
    end

    assign block_bytes = block_reg;
    assign key_bytes   = key_reg;

endmodule

// ----- sv/ssnp_scan.sv -----
// ============================================================================
// ssnp_scan: character scanner
// Registers each incoming character, steps the prefix, sign and digit state
// with one constant-radix multiply-add, and on the final character hands the
// finished scan to the scaling pipeline and clears itself.
// ============================================================================
module ssnp_scan
    import ssnp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            item_valid,
    input  logic [CH_W-1:0] ch,
    input  logic            last,
    output logic            res_valid,
    output scan_res_t       res
);

    localparam int IDX_W = $clog2(MAX_CHARS + 1);

    // Input register
    logic            in_vld_reg;
    logic [CH_W-1:0] in_ch_reg;
    logic            in_last_reg;

    // Scan state
    logic [VALUE_W-1:0] accum_reg,   accum_next;
    logic [IDX_W-1:0]   idx_reg,     idx_next;
    radix_t             radix_reg,   radix_next;
    phase_t             phase_reg,   phase_next;
    logic               neg_reg,     neg_next;
    logic               sat_reg,     sat_next;
    logic [IDX_W-1:0]   stop_reg,    stop_next;
    logic               stopped_reg, stopped_next;
    logic               sfx_reg,     sfx_next;
    logic [CH_W-1:0]    sfx_ch_reg,  sfx_ch_next;

    // Result register
    logic      res_vld_reg;
    scan_res_t res_reg, res_next;

    // Capture the character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_ch_reg   <= ch;
            in_last_reg <= last;
        end
    end

    // Next scan state for the registered character
    always_comb
    begin
        logic [VALUE_W-1:0] a_v;
        logic [IDX_W-1:0]   idx_v;
        radix_t             rad_v;
        phase_t             ph_v;
        logic               neg_v;
        logic               sat_v;
        logic [IDX_W-1:0]   stop_v;
        logic               stp_v;
        logic               hs_v;
        logic [CH_W-1:0]    sc_v;
        logic               do_take;
        logic               fin;
        logic [IDX_W-1:0]   p;
        logic [IDX_W-1:0]   nlen;
        logic [5:0]         d;
        logic [5:0]         base;
        logic [5:0]         add_base;
        logic [VALUE_W+3:0] madd;
        logic               is_dec;
        logic               is_ws;
        logic               add_en;

        a_v     = accum_reg;
        idx_v   = idx_reg;
        rad_v   = radix_reg;
        ph_v    = phase_reg;
        neg_v   = neg_reg;
        sat_v   = sat_reg;
        stop_v  = stop_reg;
        stp_v   = stopped_reg;
        hs_v    = sfx_reg;
        sc_v    = sfx_ch_reg;
        do_take = 1'b0;
        add_en  = 1'b0;
        fin     = 1'b0;
        p       = idx_reg;

        // Prefix handling before the character is counted
        case (phase_reg)
            PH_START:
            begin
                if (in_ch_reg == "0" && !in_last_reg)
                begin
                    ph_v = PH_PFX;
                end
                else
                begin
                    rad_v   = (in_ch_reg == "0") ? RM_AUTO : RM_DEC;
                    ph_v    = PH_LEAD;
                    do_take = 1'b1;
                end
            end
            PH_PFX:
            begin
                if (in_ch_reg == "x")
                begin
                    rad_v = RM_HEX;
                    ph_v  = PH_LEAD;
                end
                else
                begin
                    // The held zero counts as the first character: a lone
                    // leading zero converted in automatic base.
                    rad_v   = RM_AUTO;
                    ph_v    = PH_ZERO;
                    a_v     = '0;
                    stop_v  = IDX_W'(1);
                    idx_v   = IDX_W'(1);
                    do_take = 1'b1;
                end
            end
            default:
            begin
                do_take = 1'b1;
            end
        endcase

        // Character classes and the one multiply-add of this step
        d        = digit_of(in_ch_reg);
        base     = base_of(rad_v);
        add_base = (ph_v == PH_ZEROX) ? 6'd16 : base;
        is_dec   = in_ch_reg inside {["0":"9"]};
        is_ws    = (in_ch_reg == " ") || (in_ch_reg inside {[8'h09:8'h0D]});
        case (add_base)
            6'd8:    madd = {a_v, 3'b000} + (VALUE_W+4)'(d[3:0]);
            6'd16:   madd = {a_v, 4'b0000} + (VALUE_W+4)'(d[3:0]);
            default: madd = (VALUE_W+4)'({a_v, 3'b000}) + (VALUE_W+4)'({a_v, 1'b0})
                            + (VALUE_W+4)'(d[3:0]);
        endcase

        // Count the character: suffix test, then digit scan
        if (do_take && idx_v < IDX_W'(MAX_CHARS))
        begin
            p   = idx_v;
            fin = in_last_reg || (p == IDX_W'(MAX_CHARS - 1));
            if (fin && rad_v != RM_HEX && !is_dec)
            begin
                hs_v = 1'b1;
                sc_v = in_ch_reg;
            end
            else if (!stp_v)
            begin
                case (ph_v)
                    PH_LEAD, PH_SIGNED:
                    begin
                        if (ph_v == PH_LEAD && is_ws)
                        begin
                            stp_v = 1'b0;
                        end
                        else if (ph_v == PH_LEAD && (in_ch_reg == "+" || in_ch_reg == "-"))
                        begin
                            neg_v = (in_ch_reg == "-");
                            ph_v  = PH_SIGNED;
                        end
                        else if (in_ch_reg == "0" && rad_v != RM_DEC)
                        begin
                            a_v    = '0;
                            stop_v = p + IDX_W'(1);
                            ph_v   = PH_ZERO;
                        end
                        else if (d < base)
                        begin
                            add_en = 1'b1;
                            ph_v   = PH_DIGITS;
                        end
                        else
                        begin
                            stp_v = 1'b1;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (in_ch_reg == "x" || in_ch_reg == "X")
                        begin
                            ph_v = PH_ZEROX;
                        end
                        else
                        begin
                            ph_v = PH_DIGITS;
                            if (d < base)
                            begin
                                add_en = 1'b1;
                            end
                            else
                            begin
                                stp_v = 1'b1;
                            end
                        end
                    end
                    PH_ZEROX:
                    begin
                        if (d < 6'd16)
                        begin
                            if (rad_v == RM_AUTO)
                            begin
                                rad_v = RM_AUTOHEX;
                            end
                            add_en = 1'b1;
                            ph_v   = PH_DIGITS;
                        end
                        else
                        begin
                            stp_v = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (d < base)
                        begin
                            add_en = 1'b1;
                        end
                        else
                        begin
                            stp_v = 1'b1;
                        end
                    end
                endcase

                // Accumulate, saturating once the value leaves 64 bits
                if (add_en)
                begin
                    if (!sat_v)
                    begin
                        if (|madd[VALUE_W+3:VALUE_W])
                        begin
                            sat_v = 1'b1;
                        end
                        else
                        begin
                            a_v = madd[VALUE_W-1:0];
                        end
                    end
                    stop_v = p + IDX_W'(1);
                end
            end
            idx_v = p + IDX_W'(1);
        end

        // Finished scan for the final character
        nlen                  = idx_v - IDX_W'(hs_v);
        res_next.accum        = a_v;
        res_next.negative     = neg_v;
        res_next.saturated    = sat_v;
        res_next.converted    = (stop_v != '0);
        res_next.has_suffix   = hs_v;
        res_next.suffix_ch    = sc_v;
        res_next.stop_offset  = OFFSET_W'(stop_v);
        res_next.fully_parsed = (stop_v == nlen);

        // The final character returns the scan to its start
        if (in_last_reg)
        begin
            accum_next   = '0;
            idx_next     = '0;
            radix_next   = RM_DEC;
            phase_next   = PH_START;
            neg_next     = 1'b0;
            sat_next     = 1'b0;
            stop_next    = '0;
            stopped_next = 1'b0;
            sfx_next     = 1'b0;
            sfx_ch_next  = '0;
        end
        else
        begin
            accum_next   = a_v;
            idx_next     = idx_v;
            radix_next   = rad_v;
            phase_next   = ph_v;
            neg_next     = neg_v;
            sat_next     = sat_v;
            stop_next    = stop_v;
            stopped_next = stp_v;
            sfx_next     = hs_v;
            sfx_ch_next  = sc_v;
        end
    end

    // Scan state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg   <= '0;
            idx_reg     <= '0;
            radix_reg   <= RM_DEC;
            phase_reg   <= PH_START;
            neg_reg     <= 1'b0;
            sat_reg     <= 1'b0;
            stop_reg    <= '0;
            stopped_reg <= 1'b0;
            sfx_reg     <= 1'b0;
            sfx_ch_reg  <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= in_vld_reg && in_last_reg;
            if (in_vld_reg)
            begin
                accum_reg   <= accum_next;
                idx_reg     <= idx_next;
                radix_reg   <= radix_next;
                phase_reg   <= phase_next;
                neg_reg     <= neg_next;
                sat_reg     <= sat_next;
                stop_reg    <= stop_next;
                stopped_reg <= stopped_next;
                sfx_reg     <= sfx_next;
                sfx_ch_reg  <= sfx_ch_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

// ----- sv/ssnp_scale.sv -----
// ============================================================================
// ssnp_scale: sign, saturation and unit scaling
// Forms the signed or saturated number, applies the power-of-two part of the
// unit as a shift, multiplies by the register part in two 32-bit halves, and
// holds the finished result in the output register.
// ============================================================================
module ssnp_scale
    import ssnp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [CFG_W-1:0]    block_bytes,
    input  logic [CFG_W-1:0]    key_bytes,
    input  logic                res_valid,
    input  scan_res_t           res,
    output logic                out_valid,
    output logic [VALUE_W-1:0]  value,
    output logic [OFFSET_W-1:0] stop_offset,
    output logic                fully_parsed
);

    localparam int HALF_W = VALUE_W / 2;
    localparam int PROD_W = HALF_W + MULT_W;

    // Shift stage
    logic                vld1_reg;
    logic [VALUE_W-1:0]  shv_reg,   shv_next;
    logic [MULT_W-1:0]   mult_reg,  mult_next;
    logic [OFFSET_W-1:0] off1_reg;
    logic                full1_reg;

    // Partial product stage
    logic                vld2_reg;
    logic [PROD_W-1:0]   plo_reg;
    logic [HALF_W-1:0]   phi_reg;
    logic [PROD_W-1:0]   plo_next;
    logic [PROD_W-1:0]   phi_full;
    logic [OFFSET_W-1:0] off2_reg;
    logic                full2_reg;

    // Output register
    logic                out_vld_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic                full_reg;

    // Signed value, unit decode and shift
    always_comb
    begin
        logic [VALUE_W-1:0] v;
        logic [SHIFT_W-1:0] sh;

        if (!res.converted)
        begin
            v = '0;
        end
        else if (res.saturated)
        begin
            v = '1;
        end
        else if (res.negative)
        begin
            v = '0 - res.accum;
        end
        else
        begin
            v = res.accum;
        end

        mult_next = MULT_W'(1);
        sh        = '0;
        if (res.has_suffix)
        begin
            case (res.suffix_ch)
                "W":      sh = SHIFT_W'(1);
                "I":      sh = SHIFT_W'(2);
                "L":      sh = SHIFT_W'(3);
                "e":      mult_next = block_bytes;
                "y":      mult_next = key_bytes;
                "x":
                begin
                    mult_next = key_bytes;
                    sh        = SHIFT_W'(1);
                end
                "b", "s": sh = SHIFT_W'(9);
                "p", "S": sh = SHIFT_W'(12);
                "k", "K": sh = SHIFT_W'(10);
                "m", "M": sh = SHIFT_W'(20);
                "g", "G": sh = SHIFT_W'(30);
                "T":      sh = SHIFT_W'(40);
                "P":      sh = SHIFT_W'(50);
                default:  sh = '0;
            endcase
        end
        shv_next = v << sh;
    end

    // Two half-width partial products, product kept modulo 2^64
    assign plo_next = PROD_W'(shv_reg[HALF_W-1:0]) * PROD_W'(mult_reg);
    assign phi_full = PROD_W'(shv_reg[VALUE_W-1:HALF_W]) * PROD_W'(mult_reg);

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld1_reg    <= res_valid;
            vld2_reg    <= vld1_reg;
            out_vld_reg <= vld2_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            shv_reg   <= shv_next;
            mult_reg  <= mult_next;
            off1_reg  <= res.stop_offset;
            full1_reg <= res.fully_parsed;
            plo_reg   <= plo_next;
            phi_reg   <= phi_full[HALF_W-1:0];
            off2_reg  <= off1_reg;
            full2_reg <= full1_reg;
            value_reg <= {phi_reg, {HALF_W{1'b0}}} + VALUE_W'(plo_reg);
            off_reg   <= off2_reg;
            full_reg  <= full2_reg;
        end
    end

    assign out_valid    = out_vld_reg;
    assign value        = value_reg;
    assign stop_offset  = off_reg;
    assign fully_parsed = full_reg;

endmodule

// ----- sv/size_suffix_number_parser.sv -----
// ============================================================================
// size_suffix_number_parser: size string to byte count
// Reads a size string one character per item, with hex, octal and decimal
// prefixes, sign and unit suffix, and returns the scaled value on the last
// character.
//
//   Channel   Direction  Handshake                   Payload
//   item      in         item_valid / item_stall     ch, last
//   result    out        result_valid / result_stall value, stop_offset,
//                                                    fully_parsed
//   config    in         psel, penable, pwrite       paddr, pwdata, prdata
//
// One character is taken every cycle while item_stall is low; the scan state
// steps once per item. After its last character is taken, a result passes
// through the input register, scan, shift, partial products and output register.
// The whole pipeline holds while a result waits under result_stall, and
// item_stall follows it; an empty output register never stalls the input.
// Reset clears the scan state and sets both size registers to 64.
// ============================================================================
module size_suffix_number_parser
    import ssnp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [CH_W-1:0]     ch,
    input  logic                last,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [VALUE_W-1:0]  value,
    output logic [OFFSET_W-1:0] stop_offset,
    output logic                fully_parsed,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic             advance;
    logic [CFG_W-1:0] block_bytes;
    logic [CFG_W-1:0] key_bytes;
    logic             res_valid;
    scan_res_t        res;

    // The pipeline moves unless a result is waiting to be taken.
    assign advance    = !(result_valid && result_stall);
    assign item_stall = !advance;

    ssnp_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .block_bytes (block_bytes),
        .key_bytes   (key_bytes)
    );

    ssnp_scan #(
        .MAX_CHARS (MAX_CHARS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (item_valid),
        .ch         (ch),
        .last       (last),
        .res_valid  (res_valid),
        .res        (res)
    );

    ssnp_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .block_bytes  (block_bytes),
        .key_bytes    (key_bytes),
        .res_valid    (res_valid),
        .res          (res),
        .out_valid    (result_valid),
        .value        (value),
        .stop_offset  (stop_offset),
        .fully_parsed (fully_parsed)
    );

endmodule

// ----- sv/ssnp_checker.sv -----
// ============================================================================
// ssnp_checker: port-level checks of the size suffix number parser
// Watches the top level's ports for reset, flow control and result sanity.
// ============================================================================
module ssnp_checker
    import ssnp_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input logic [VALUE_W-1:0]  value,
    input logic [OFFSET_W-1:0] stop_offset,
    input logic                fully_parsed
);

    localparam bit OFFSET_FITS = (MAX_CHARS < (1 << OFFSET_W));

    // No result is offered in the cycle after reset has been seen.
    assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result offered during reset");

    // The input is only held back by a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(result_valid && result_stall) |-> !item_stall)
        else $error("input stalled with no result waiting");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(value) && $stable(stop_offset)
            && $stable(fully_parsed))
        else $error("stalled result changed");

    // The stop offset never runs past the counted characters.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && OFFSET_FITS |-> stop_offset <= OFFSET_W'(MAX_CHARS))
        else $error("stop offset beyond character limit");

    // With nothing converted the value is zero, whatever the unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && OFFSET_FITS && stop_offset == '0 |-> value == '0)
        else $error("non-zero value with no digit converted");

endmodule

bind size_suffix_number_parser ssnp_checker #(.MAX_CHARS(MAX_CHARS)) u_ssnp_checker (.*);
